>>> rtl/vmsr_pkg.sv
// ============================================================================
// vmsr_pkg: shared types and constants of the von Mises stress limiter
// Word layouts of the input, middle and result queues, fixed-point widths
// and configuration register indexes.
// ============================================================================
package vmsr_pkg;

    // fixed-point formats
    localparam int FRAC_BITS   = 16;
    localparam int FACT_W      = FRAC_BITS + 1;
    localparam int DATA_WIDTH  = 32;
    localparam int CFG_W       = 31;
    localparam int NUM_LANES   = 5;
    localparam int QUEUE_DEPTH = 4;

    // derived datapath widths
    localparam int SQ_W       = 2 * DATA_WIDTH + 2;
    localparam int Q3_W       = SQ_W + 2;
    localparam int ROOT_W     = Q3_W + 2 * FACT_W + 1;
    localparam int DIV_STEPS  = CFG_W;
    localparam int ROOT_STEPS = FACT_W;

    localparam logic [FACT_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // below energy/melt = 1e-5 the full limit applies
    localparam int RATIO_W = 17;
    localparam logic [RATIO_W-1:0] ENERGY_RATIO = 17'd100000;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ELASTIC_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MELT_ENERGY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMAGE_ENABLED = 2'd2;

    localparam logic [CFG_W-1:0] ELASTIC_RESET = 31'd65536;
    localparam logic [CFG_W-1:0] MELT_RESET    = 31'd65536;

    typedef struct packed {
        logic [CFG_W-1:0] elastic_limit;
        logic [CFG_W-1:0] melt_level;
        logic             damage_enabled;
    } t_cfg;

    typedef struct packed {
        logic [CFG_W-1:0]              energy;
        logic [FACT_W-1:0]             damage;
        logic signed [DATA_WIDTH-1:0]  stress_xx;
        logic signed [DATA_WIDTH-1:0]  stress_yy;
        logic signed [DATA_WIDTH-1:0]  stress_xy;
        logic signed [DATA_WIDTH-1:0]  stress_xz;
        logic signed [DATA_WIDTH-1:0]  stress_yz;
    } t_in_word;

    typedef struct packed {
        logic [FACT_W-1:0]             reduce_factor;
        logic signed [DATA_WIDTH-1:0]  out_xx;
        logic signed [DATA_WIDTH-1:0]  out_yy;
        logic signed [DATA_WIDTH-1:0]  out_xy;
        logic signed [DATA_WIDTH-1:0]  out_xz;
        logic signed [DATA_WIDTH-1:0]  out_yz;
    } t_out_word;

    // classified particle handed from front to back; lanes xx, yy, xy, xz, yz
    typedef struct packed {
        logic                                  yzero;
        logic [CFG_W-1:0]                      y;
        logic [NUM_LANES-1:0]                  neg;
        logic [NUM_LANES-1:0][DATA_WIDTH-1:0]  mag;
        logic [NUM_LANES-1:0][DATA_WIDTH-1:0]  smag;
    } t_mid_word;

endpackage

>>> rtl/von_mises_stress_reduction.sv
// Throughput: one word per cycle when nothing stalls, set by the fully pipelined
//   31-stage yield divider and 17-stage reduction factor search.
// Reset: synchronous, active low; queues empty, registers back to their
//   defaults (limit 65536, melt energy 65536, damage off).
// ============================================================================
// von_mises_stress_reduction: von Mises plastic stress limiter
// Front section classifies particles and derives yield stress; a queue
// decouples it from the back section that reduces and scales the stress.
// ============================================================================
module von_mises_stress_reduction #(
    parameter int QUEUE_DEPTH = vmsr_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [vmsr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [vmsr_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              push,
    output logic                              full,
    input  vmsr_pkg::t_in_word                i_word,
    output logic                              empty,
    input  logic                              pop,
    output vmsr_pkg::t_out_word               o_word
);

    vmsr_pkg::t_cfg      r_cfg;
    vmsr_pkg::t_mid_word w_front_word, w_mid_word;
    vmsr_pkg::t_out_word w_back_word;
    logic                w_mid_push, w_mid_full, w_mid_pop, w_mid_empty;
    logic                w_out_push, w_out_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.elastic_limit  <= vmsr_pkg::ELASTIC_RESET;
            r_cfg.melt_level     <= vmsr_pkg::MELT_RESET;
            r_cfg.damage_enabled <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vmsr_pkg::CFG_ELASTIC_LIMIT:  r_cfg.elastic_limit  <= i_cfg_data;
                vmsr_pkg::CFG_MELT_ENERGY:    r_cfg.melt_level     <= i_cfg_data;
                vmsr_pkg::CFG_DAMAGE_ENABLED: r_cfg.damage_enabled <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    vmsr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (push),
        .o_full     (full),
        .i_word     (i_word),
        .o_mid_push (w_mid_push),
        .i_mid_full (w_mid_full),
        .o_mid_word (w_front_word)
    );

    vmsr_fifo #(
        .DEPTH  (QUEUE_DEPTH),
        .t_word (vmsr_pkg::t_mid_word)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_front_word),
        .o_full  (w_mid_full),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_word),
        .o_empty (w_mid_empty)
    );

    vmsr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (w_mid_empty),
        .o_mid_pop   (w_mid_pop),
        .i_mid_word  (w_mid_word),
        .o_out_push  (w_out_push),
        .i_out_full  (w_out_full),
        .o_out_word  (w_back_word)
    );

    vmsr_fifo #(
        .DEPTH  (QUEUE_DEPTH),
        .t_word (vmsr_pkg::t_out_word)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_back_word),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (o_word),
        .o_empty (empty)
    );

endmodule

>>> rtl/vmsr_fifo.sv
// ============================================================================
// vmsr_fifo: small register queue
// Holds words between pipeline sections; the head word is shown while the
// queue is not empty.
// ============================================================================
module vmsr_fifo #(
    parameter int DEPTH = 4,
    parameter type t_word = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_word i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_word o_data,
    output logic  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_word          r_mem [DEPTH];
    logic [AW-1:0]  r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           w_do_push, w_do_pop;

    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd];

    // advance pointers with wrap at the depth
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (w_do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // store the incoming word
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("vmsr_fifo: count beyond depth");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("vmsr_fifo: push into a full queue");
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full && !i_pop) |=> !o_empty)
        else $error("vmsr_fifo: pushed word lost");
`endif

endmodule

>>> rtl/vmsr_front.sv
// ============================================================================
// vmsr_front: particle intake and yield classification
// Forms stress magnitudes, the yield stress (pipelined restoring divider)
// and the damage-weakened stress magnitudes.
// ============================================================================
module vmsr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vmsr_pkg::t_cfg      i_cfg,
    input  logic                i_push,
    output logic                o_full,
    input  vmsr_pkg::t_in_word  i_word,
    output logic                o_mid_push,
    input  logic                i_mid_full,
    output vmsr_pkg::t_mid_word o_mid_word
);

    localparam int DW   = vmsr_pkg::DATA_WIDTH;
    localparam int FB   = vmsr_pkg::FRAC_BITS;
    localparam int FW   = vmsr_pkg::FACT_W;
    localparam int EW   = vmsr_pkg::CFG_W;
    localparam int NL   = vmsr_pkg::NUM_LANES;
    localparam int RTW  = vmsr_pkg::RATIO_W;
    localparam int DIVN = vmsr_pkg::DIV_STEPS;
    localparam int NST  = DIVN + 4;

    localparam logic [1:0] CLS_FULL = 2'd0;
    localparam logic [1:0] CLS_ZERO = 2'd1;
    localparam logic [1:0] CLS_DIV  = 2'd2;

    typedef struct packed {
        logic [1:0]            cls;
        logic [FW-1:0]         fac;
        logic [NL-1:0]         neg;
        logic [NL-1:0][DW-1:0] mag;
    } t_fcarry;

    logic [NST-1:0] r_v;
    logic           w_en, w_accept;

    assign w_en       = !(r_v[NST-1] && i_mid_full);
    assign o_full     = !w_en;
    assign w_accept   = i_push && w_en;
    assign o_mid_push = r_v[NST-1] && !i_mid_full;

    // shift valid bits while the section advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NST-2:0], w_accept};
        end
    end

    // stage 1: magnitudes, energy class, damage clamp
    logic [NL-1:0][DW-1:0] w_raw;
    logic [EW+RTW-1:0]     w_escaled;
    t_fcarry               w_s1;

    always_comb begin
        w_raw[0] = i_word.stress_xx;
        w_raw[1] = i_word.stress_yy;
        w_raw[2] = i_word.stress_xy;
        w_raw[3] = i_word.stress_xz;
        w_raw[4] = i_word.stress_yz;
        for (int i = 0; i < NL; i++) begin
            w_s1.neg[i] = w_raw[i][DW-1];
            w_s1.mag[i] = w_raw[i][DW-1] ? (~w_raw[i] + DW'(1)) : w_raw[i];
        end
        w_escaled = (EW+RTW)'(i_word.energy) * (EW+RTW)'(vmsr_pkg::ENERGY_RATIO);
        priority if (i_cfg.melt_level == '0) begin
            w_s1.cls = CLS_ZERO;
        end else if (w_escaled < (EW+RTW)'(i_cfg.melt_level)) begin
            w_s1.cls = CLS_FULL;
        end else if (i_word.energy >= i_cfg.melt_level) begin
            w_s1.cls = CLS_ZERO;
        end else begin
            w_s1.cls = CLS_DIV;
        end
        w_s1.fac = (i_word.damage > vmsr_pkg::ONE) ? vmsr_pkg::ONE : i_word.damage;
    end

    t_fcarry         r_s1, r_s2, r_s3;
    logic [EW-1:0]   r_s1_diff;
    logic [FW-1:0]   r_s2_dsq;
    logic [2*EW-1:0] r_s2_num, r_s3_num;
    logic [2*FW-1:0] w_dsq_full, w_d3_full;
    logic [FW-1:0]   w_d3;
    t_fcarry         w_s3;

    // damage cube: D*D, then times D, each truncated
    assign w_dsq_full = (2*FW)'(r_s1.fac) * (2*FW)'(r_s1.fac);
    assign w_d3_full  = (2*FW)'(r_s2_dsq) * (2*FW)'(r_s2.fac);
    assign w_d3       = w_d3_full[FB+FW-1:FB];

    always_comb begin
        w_s3     = r_s2;
        w_s3.fac = i_cfg.damage_enabled ? (vmsr_pkg::ONE - w_d3) : vmsr_pkg::ONE;
    end

    // stages 1 to 3
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1      <= w_s1;
            r_s1_diff <= i_cfg.melt_level - i_word.energy;
            r_s2      <= r_s1;
            r_s2_dsq  <= w_dsq_full[FB+FW-1:FB];
            r_s2_num  <= (2*EW)'(i_cfg.elastic_limit) * (2*EW)'(r_s1_diff);
            r_s3      <= w_s3;
            r_s3_num  <= r_s2_num;
        end
    end

    // restoring divider: one quotient bit per stage
    t_fcarry       r_dv_c   [DIVN];
    logic [EW-1:0] r_dv_rem [DIVN];
    logic [EW-1:0] r_dv_low [DIVN];
    logic [EW-1:0] r_dv_q   [DIVN];

    for (genvar j = 0; j < DIVN; j++) begin : g_div
        logic [EW-1:0] w_rem_in, w_low_in, w_q_in;
        t_fcarry       w_c_in;
        logic [EW:0]   w_trial;
        logic          w_ge;

        if (j == 0) begin : g_first
            assign w_rem_in = r_s3_num[2*EW-1:EW];
            assign w_low_in = r_s3_num[EW-1:0];
            assign w_q_in   = '0;
            assign w_c_in   = r_s3;
        end else begin : g_next
            assign w_rem_in = r_dv_rem[j-1];
            assign w_low_in = r_dv_low[j-1];
            assign w_q_in   = r_dv_q[j-1];
            assign w_c_in   = r_dv_c[j-1];
        end

        assign w_trial = {w_rem_in, w_low_in[EW-1]};
        assign w_ge    = (w_trial >= {1'b0, i_cfg.melt_level});

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_rem[j] <= w_ge ? EW'(w_trial - {1'b0, i_cfg.melt_level})
                                    : w_trial[EW-1:0];
                r_dv_low[j] <= {w_low_in[EW-2:0], 1'b0};
                r_dv_q[j]   <= {w_q_in[EW-2:0], w_ge};
                r_dv_c[j]   <= w_c_in;
            end
        end
    end

    // final stage: pick yield stress, weaken stress by damage factor
    t_fcarry              w_last;
    vmsr_pkg::t_mid_word  w_out, r_out;
    logic [DW+FW-1:0]     w_prod [NL];

    assign w_last = r_dv_c[DIVN-1];

    always_comb begin
        unique case (w_last.cls)
            CLS_FULL: w_out.y = i_cfg.elastic_limit;
            CLS_DIV:  w_out.y = r_dv_q[DIVN-1];
            default:  w_out.y = '0;
        endcase
        w_out.yzero = (w_out.y == '0);
        w_out.neg   = w_last.neg;
        w_out.mag   = w_last.mag;
        for (int i = 0; i < NL; i++) begin
            w_prod[i]     = (DW+FW)'(w_last.mag[i]) * (DW+FW)'(w_last.fac);
            w_out.smag[i] = w_prod[i][FB+DW-1:FB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= w_out;
        end
    end

    assign o_mid_word = r_out;

endmodule

>>> rtl/vmsr_back.sv
// ============================================================================
// vmsr_back: contraction, reduction factor search and stress scaling
// Sums the double contraction, finds the reduction factor one bit per
// stage with incremental squares, and scales the original stress.
// ============================================================================
module vmsr_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_mid_empty,
    output logic                 o_mid_pop,
    input  vmsr_pkg::t_mid_word  i_mid_word,
    output logic                 o_out_push,
    input  logic                 i_out_full,
    output vmsr_pkg::t_out_word  o_out_word
);

    localparam int DW  = vmsr_pkg::DATA_WIDTH;
    localparam int FB  = vmsr_pkg::FRAC_BITS;
    localparam int FW  = vmsr_pkg::FACT_W;
    localparam int EW  = vmsr_pkg::CFG_W;
    localparam int NL  = vmsr_pkg::NUM_LANES;
    localparam int SQW = vmsr_pkg::SQ_W;
    localparam int Q3W = vmsr_pkg::Q3_W;
    localparam int RW  = vmsr_pkg::ROOT_W;
    localparam int RTN = vmsr_pkg::ROOT_STEPS;
    localparam int NST = RTN + 6;

    typedef struct packed {
        logic                  yzero;
        logic [NL-1:0]         neg;
        logic [NL-1:0][DW-1:0] mag;
    } t_bcarry;

    logic [NST-1:0] r_v;
    logic           w_en;

    assign w_en       = !(r_v[NST-1] && i_out_full);
    assign o_mid_pop  = !i_mid_empty && w_en;
    assign o_out_push = r_v[NST-1] && !i_out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NST-2:0], o_mid_pop};
        end
    end

    // stage 1: magnitude of zz = -(xx + yy)
    t_bcarry w_in_c;
    logic [DW:0] w_sz, w_s0, w_s1;

    always_comb begin
        w_in_c.yzero = i_mid_word.yzero;
        w_in_c.neg   = i_mid_word.neg;
        w_in_c.mag   = i_mid_word.mag;
        w_s0 = (DW+1)'(i_mid_word.smag[0]);
        w_s1 = (DW+1)'(i_mid_word.smag[1]);
        if (i_mid_word.neg[0] == i_mid_word.neg[1]) begin
            w_sz = w_s0 + w_s1;
        end else begin
            w_sz = (w_s0 > w_s1) ? (w_s0 - w_s1) : (w_s1 - w_s0);
        end
    end

    t_bcarry               r_b1_c, r_b2_c, r_b3_c, r_b4_c, r_b5_c;
    logic [EW-1:0]         r_b1_y, r_b2_y;
    logic [NL-1:0][DW-1:0] r_b1_smag;
    logic [DW:0]           r_b1_sz;
    logic [SQW-1:0]        r_b2_sq [6];
    logic [SQW-1:0]        r_b3_a, r_b3_b, r_b3_c_sum, r_b4_q;
    logic [2*EW-1:0]       r_b3_ysq, r_b4_ysq;
    logic [Q3W-1:0]        r_b5_q3;
    logic [RW-1:0]         r_b5_rhs;

    // stages 1 to 5: squares, adder tree, 3Q and the right-hand side
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b1_c     <= w_in_c;
            r_b1_y     <= i_mid_word.y;
            r_b1_smag  <= i_mid_word.smag;
            r_b1_sz    <= w_sz;

            r_b2_c     <= r_b1_c;
            r_b2_y     <= r_b1_y;
            r_b2_sq[0] <= SQW'((2*DW)'(r_b1_smag[0]) * (2*DW)'(r_b1_smag[0]));
            r_b2_sq[1] <= SQW'((2*DW)'(r_b1_smag[1]) * (2*DW)'(r_b1_smag[1]));
            r_b2_sq[2] <= SQW'(r_b1_sz) * SQW'(r_b1_sz);
            r_b2_sq[3] <= SQW'((2*DW)'(r_b1_smag[2]) * (2*DW)'(r_b1_smag[2]));
            r_b2_sq[4] <= SQW'((2*DW)'(r_b1_smag[3]) * (2*DW)'(r_b1_smag[3]));
            r_b2_sq[5] <= SQW'((2*DW)'(r_b1_smag[4]) * (2*DW)'(r_b1_smag[4]));

            r_b3_c     <= r_b2_c;
            r_b3_a     <= r_b2_sq[0] + r_b2_sq[1];
            r_b3_b     <= r_b2_sq[2] + (r_b2_sq[3] << 1);
            r_b3_c_sum <= (r_b2_sq[4] << 1) + (r_b2_sq[5] << 1);
            r_b3_ysq   <= (2*EW)'(r_b2_y) * (2*EW)'(r_b2_y);

            r_b4_c     <= r_b3_c;
            r_b4_q     <= r_b3_a + r_b3_b + r_b3_c_sum;
            r_b4_ysq   <= r_b3_ysq;

            r_b5_c     <= r_b4_c;
            r_b5_q3    <= Q3W'(r_b4_q) + (Q3W'(r_b4_q) << 1);
            r_b5_rhs   <= RW'(r_b4_ysq) << (2*FB + 1);
        end
    end

    // factor search: keep P = 3Q r^2 and A = 3Q r to try each bit with adds
    t_bcarry        r_rt_c   [RTN];
    logic [RW-1:0]  r_rt_p   [RTN];
    logic [RW-1:0]  r_rt_a   [RTN];
    logic [FW-1:0]  r_rt_r   [RTN];
    logic [Q3W-1:0] r_rt_q3  [RTN];
    logic [RW-1:0]  r_rt_rhs [RTN];

    for (genvar k = 0; k < RTN; k++) begin : g_root
        localparam int BIT = FB - k;
        logic [RW-1:0]  w_p_in, w_a_in, w_rhs_in, w_cand;
        logic [FW-1:0]  w_r_in;
        logic [Q3W-1:0] w_q3_in;
        t_bcarry        w_c_in;
        logic           w_ok;

        if (k == 0) begin : g_first
            assign w_p_in   = '0;
            assign w_a_in   = '0;
            assign w_r_in   = '0;
            assign w_q3_in  = r_b5_q3;
            assign w_rhs_in = r_b5_rhs;
            assign w_c_in   = r_b5_c;
        end else begin : g_next
            assign w_p_in   = r_rt_p[k-1];
            assign w_a_in   = r_rt_a[k-1];
            assign w_r_in   = r_rt_r[k-1];
            assign w_q3_in  = r_rt_q3[k-1];
            assign w_rhs_in = r_rt_rhs[k-1];
            assign w_c_in   = r_rt_c[k-1];
        end

        assign w_cand = w_p_in + (w_a_in << (BIT + 1)) + (RW'(w_q3_in) << (2 * BIT));
        // a factor of one already reached admits no further bit
        assign w_ok   = !w_r_in[FB] && (w_cand <= w_rhs_in);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rt_p[k]   <= w_ok ? w_cand : w_p_in;
                r_rt_a[k]   <= w_ok ? (w_a_in + (RW'(w_q3_in) << BIT)) : w_a_in;
                r_rt_r[k]   <= w_ok ? (w_r_in | (FW'(1) << BIT)) : w_r_in;
                r_rt_q3[k]  <= w_q3_in;
                r_rt_rhs[k] <= w_rhs_in;
                r_rt_c[k]   <= w_c_in;
            end
        end
    end

    // scale the original stress; zero yield drops everything to zero
    t_bcarry               w_last;
    logic [FW-1:0]         w_r;
    logic [DW+FW-1:0]      w_prod [NL];
    logic [NL-1:0][DW-1:0] w_val;
    vmsr_pkg::t_out_word   w_out, r_out;

    assign w_last = r_rt_c[RTN-1];

    always_comb begin
        w_r = w_last.yzero ? '0 : r_rt_r[RTN-1];
        for (int i = 0; i < NL; i++) begin
            w_prod[i] = (DW+FW)'(w_last.mag[i]) * (DW+FW)'(w_r);
            w_val[i]  = w_last.neg[i] ? (~w_prod[i][FB+DW-1:FB] + DW'(1))
                                      : w_prod[i][FB+DW-1:FB];
        end
        w_out.reduce_factor = w_r;
        w_out.out_xx        = w_val[0];
        w_out.out_yy        = w_val[1];
        w_out.out_xy        = w_val[2];
        w_out.out_xz        = w_val[3];
        w_out.out_yz        = w_val[4];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= w_out;
        end
    end

    assign o_out_word = r_out;

endmodule

>>> test/tb_von_mises_stress_reduction.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_von_mises_stress_reduction: self-checking bench of the stress limiter
// Streams particles through the block under several register settings and
// random queue stalls. A scoreboard predicts each result word and compares
// it field by field with what the block returns, oldest first.
// ============================================================================
module tb_von_mises_stress_reduction;

    localparam int  RANDOM_WORDS = 550;
    localparam int  NUM_PHASES   = 6;
    localparam int  DRAIN_CYCLES = 80;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam logic [vmsr_pkg::CFG_W-1:0] CFG_MAX = 31'h7FFF_FFFF;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [vmsr_pkg::CFG_IDX_W-1:0]     i_cfg_idx;
    logic [vmsr_pkg::CFG_W-1:0]         i_cfg_data;
    logic                               push;
    logic                               full;
    vmsr_pkg::t_in_word                 i_word;
    logic                               empty;
    logic                               pop;
    vmsr_pkg::t_out_word                o_word;

    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned rx_hold = 0;

    von_mises_stress_reduction dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .push(push), .full(full), .i_word(i_word),
        .empty(empty), .pop(pop), .o_word(o_word)
    );

    // print one mismatch line and count it
    task automatic report(input string what);
        mismatches++;
        $display("MISMATCH at cycle %0d: %s", cycles, what);
    endtask

    // ------------------------------------------------------------------------
    // Scoreboard: limiter predictor and queue of expected result words
    // ------------------------------------------------------------------------
    class stress_scoreboard;
        logic [63:0]          limit_reg;
        logic [63:0]          melt_reg;
        bit                   damage_on;
        vmsr_pkg::t_out_word  pending[$];
        int unsigned          checked;

        function new();
            limit_reg = 64'(vmsr_pkg::ELASTIC_RESET);
            melt_reg  = 64'(vmsr_pkg::MELT_RESET);
            damage_on = 1'b0;
            checked   = 0;
        endfunction

        function automatic logic [127:0] square(input logic [63:0] a);
            logic [127:0] w;
            w = {64'b0, a};
            return w * w;
        endfunction

        function automatic vmsr_pkg::t_out_word limit_stress(input vmsr_pkg::t_in_word w);
            logic [31:0]          comp[5];
            logic [63:0]          mag[5];
            logic [63:0]          smag[5];
            bit                   neg[5];
            logic [63:0]          energy, yld, dmg, d3, fac, sz, red, trial, m;
            logic [127:0]         q, rhs, lhs;
            logic [31:0]          res;
            vmsr_pkg::t_out_word  o;
            comp[0] = w.stress_xx;
            comp[1] = w.stress_yy;
            comp[2] = w.stress_xy;
            comp[3] = w.stress_xz;
            comp[4] = w.stress_yz;
            o = '0;
            energy = 64'(w.energy);
            // yield stress falls linearly to zero at the melt energy
            if (melt_reg == 0) yld = 0;
            else if (energy * 64'd100000 < melt_reg) yld = limit_reg;
            else if (energy >= melt_reg) yld = 0;
            else yld = limit_reg * (melt_reg - energy) / melt_reg;
            if (yld == 0) return o;
            for (int i = 0; i < 5; i++) begin
                neg[i] = comp[i][31];
                res    = neg[i] ? -comp[i] : comp[i];
                mag[i] = {32'b0, res};
            end
            fac = 64'd65536;
            if (damage_on) begin
                dmg = (w.damage > 17'd65536) ? 64'd65536 : 64'(w.damage);
                d3  = (((dmg * dmg) >> 16) * dmg) >> 16;
                fac = 64'd65536 - d3;
            end
            for (int i = 0; i < 5; i++) smag[i] = (mag[i] * fac) >> 16;
            // zz is minus the sum of xx and yy
            if (neg[0] == neg[1]) sz = smag[0] + smag[1];
            else sz = (smag[0] > smag[1]) ? smag[0] - smag[1] : smag[1] - smag[0];
            q = square(smag[0]) + square(smag[1]) + square(sz);
            for (int i = 2; i < 5; i++) q = q + 2 * square(smag[i]);
            rhs = square(yld) << 33;
            // largest factor with 3 r^2 Q <= 2^33 y^2, one bit at a time
            red = 0;
            for (int b = 16; b >= 0; b--) begin
                trial = red | (64'd1 << b);
                lhs   = q * (128'd3 * {64'b0, trial} * {64'b0, trial});
                if (trial <= 64'd65536 && lhs <= rhs) red = trial;
            end
            o.reduce_factor = red[16:0];
            for (int i = 0; i < 5; i++) begin
                m = (mag[i] * red) >> 16;
                comp[i] = neg[i] ? -m[31:0] : m[31:0];
            end
            o.out_xx = comp[0];
            o.out_yy = comp[1];
            o.out_xy = comp[2];
            o.out_xz = comp[3];
            o.out_yz = comp[4];
            return o;
        endfunction

        // note an accepted particle
        function void note_particle(input vmsr_pkg::t_in_word w);
            pending.push_back(limit_stress(w));
        endfunction

        // check one popped result word against the oldest expectation
        task check_result(input vmsr_pkg::t_out_word got);
            vmsr_pkg::t_out_word want;
            checked++;
            if (pending.size() == 0) begin
                report("result word with nothing expected");
                return;
            end
            want = pending.pop_front();
            if (got.reduce_factor !== want.reduce_factor)
                report($sformatf("reduce_factor got %0d want %0d",
                                 got.reduce_factor, want.reduce_factor));
            if (got.out_xx !== want.out_xx)
                report($sformatf("out_xx got %0d want %0d", got.out_xx, want.out_xx));
            if (got.out_yy !== want.out_yy)
                report($sformatf("out_yy got %0d want %0d", got.out_yy, want.out_yy));
            if (got.out_xy !== want.out_xy)
                report($sformatf("out_xy got %0d want %0d", got.out_xy, want.out_xy));
            if (got.out_xz !== want.out_xz)
                report($sformatf("out_xz got %0d want %0d", got.out_xz, want.out_xz));
            if (got.out_yz !== want.out_yz)
                report($sformatf("out_yz got %0d want %0d", got.out_yz, want.out_yz));
        endtask
    endclass

    stress_scoreboard sb = new();

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle count and timeout
    initial begin
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // result side: random pops, long hold-offs on request
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                rx_hold--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= rx_idle_pct);
            end
            @(posedge i_clk);
            if (pop && !empty) sb.check_result(o_word);
        end
    end

    // push one particle word, idling at random before it
    task automatic send_particle(input vmsr_pkg::t_in_word w);
        bit done;
        done = 0;
        while (!done) begin
            @(negedge i_clk);
            if ($urandom_range(99) < tx_idle_pct) begin
                push <= 1'b0;
            end else begin
                push   <= 1'b1;
                i_word <= w;
                do @(posedge i_clk); while (full);
                sb.note_particle(w);
                done = 1;
            end
        end
    endtask

    // wait for every expected word, then let the pipeline settle
    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // write one register while the block is idle
    task automatic write_reg(input logic [vmsr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [vmsr_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            vmsr_pkg::CFG_ELASTIC_LIMIT:  sb.limit_reg = 64'(val);
            vmsr_pkg::CFG_MELT_ENERGY:    sb.melt_reg  = 64'(val);
            vmsr_pkg::CFG_DAMAGE_ENABLED: sb.damage_on = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [vmsr_pkg::CFG_W-1:0] lim,
                              input logic [vmsr_pkg::CFG_W-1:0] melt,
                              input bit dmg_on);
        write_reg(vmsr_pkg::CFG_ELASTIC_LIMIT, lim);
        write_reg(vmsr_pkg::CFG_MELT_ENERGY, melt);
        write_reg(vmsr_pkg::CFG_DAMAGE_ENABLED, {30'b0, dmg_on});
    endtask

    function automatic vmsr_pkg::t_in_word make_word(input logic [30:0] e,
                                                     input logic [16:0] d,
                                                     input logic [31:0] xx,
                                                     input logic [31:0] yy,
                                                     input logic [31:0] xy,
                                                     input logic [31:0] xz,
                                                     input logic [31:0] yz);
        vmsr_pkg::t_in_word w;
        w.energy    = e;
        w.damage    = d;
        w.stress_xx = xx;
        w.stress_yy = yy;
        w.stress_xy = xy;
        w.stress_xz = xz;
        w.stress_yz = yz;
        return w;
    endfunction

    // stress component mostly near the yield scale, sometimes anything
    function automatic logic [31:0] rand_stress(input logic [63:0] scale);
        logic [31:0] m;
        case ($urandom_range(7))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2: return 32'($urandom_range(3)) - 32'd1;
            default: begin
                m = $urandom_range(0, (scale > 64'h3FFF_FFFF) ? 32'h7FFF_FFFF
                                                               : 32'(scale * 2));
                return $urandom_range(1) ? -m : m;
            end
        endcase
    endfunction

    function automatic logic [30:0] rand_energy(input logic [63:0] melt);
        case ($urandom_range(5))
            0: return 31'($urandom_range(0, 32'(melt / 100000)));
            1, 2: return 31'($urandom_range(32'(melt / 100000), 32'(melt)));
            3: return 31'($urandom_range(32'(melt), 32'h7FFF_FFFF));
            4: return 31'($urandom_range(1) ? 0 : melt - 1);
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic logic [16:0] rand_damage();
        case ($urandom_range(3))
            0: return 17'd0;
            1: return 17'd65536;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // main sequence
    initial begin
        logic [vmsr_pkg::CFG_W-1:0] lims[NUM_PHASES];
        logic [vmsr_pkg::CFG_W-1:0] melts[NUM_PHASES];
        bit                         dmgs[NUM_PHASES];
        logic [63:0]                scale;
        vmsr_pkg::t_in_word         w;

        lims  = '{31'd65536, 31'd1, CFG_MAX, CFG_MAX, 31'd5000000, 31'd123457};
        melts = '{31'd65536, CFG_MAX, 31'd1, CFG_MAX, 31'd100000000, 31'd70000};
        dmgs  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        push       = 1'b0;
        i_word     = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes and special cases under the reset settings, then with damage on
        send_particle(make_word(31'd0, 17'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
        send_particle(make_word(31'h7FFF_FFFF, 17'd65536, 32'd5, 32'd6, 32'd7, 32'd8, 32'd9));
        send_particle(make_word(31'd65536, 17'd0, 32'd100, 32'd0, 32'd0, 32'd0, 32'd0));
        send_particle(make_word(31'd65535, 17'd0, 32'd1000, -32'd1000, 32'd0, 32'd0, 32'd0));
        send_particle(make_word(31'd0, 17'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_particle(make_word(31'd0, 17'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 32'h8000_0000));
        send_particle(make_word(31'd0, 17'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd1,
                                -32'd1));
        send_particle(make_word(31'd1000, 17'h1FFFF & 17'd65536, 32'd30000, 32'd20000,
                                -32'd10000, 32'd5000, -32'd7000));
        send_particle(make_word(31'd32768, 17'd32768, 32'd40000, 32'd40000, 32'd0, 32'd0,
                                32'd0));
        send_particle(make_word(31'd0, 17'd0, 32'd26755, -32'd26755, 32'd0, 32'd0, 32'd0));
        drain();
        write_reg(vmsr_pkg::CFG_DAMAGE_ENABLED, 31'd1);
        send_particle(make_word(31'd0, 17'd65536, 32'h7FFF_FFFF, 32'h8000_0000, 32'd5,
                                32'd6, 32'd7));
        send_particle(make_word(31'd0, 17'd0, 32'd500000, 32'd500000, 32'd0, 32'd0, 32'd0));
        send_particle(make_word(31'd0, 17'd32768, 32'd500000, -32'd400000, 32'd300000,
                                32'd0, 32'd0));
        send_particle(make_word(31'd0, 17'd65535, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0,
                                32'd0, 32'd0));
        send_particle(make_word(31'd65536, 17'd1000, 32'd100, 32'd100, 32'd100, 32'd100,
                                32'd100));
        drain();

        // random phases under several settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_config(lims[p], melts[p], dmgs[p]);
            if (p < 2) begin
                tx_idle_pct = 11;
                rx_idle_pct = 77;
            end else if (p < 4) begin
                tx_idle_pct = 77;
                rx_idle_pct = 11;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // hold the result side off so the block fills and stalls its input
            if (p == 0 || p == 4) rx_hold = 300;
            scale = sb.limit_reg;
            for (int n = 0; n < RANDOM_WORDS / NUM_PHASES; n++) begin
                // pause the sender until every expected word is back
                if (p == 2 && n == 40) begin
                    @(negedge i_clk);
                    push <= 1'b0;
                    while (sb.pending.size() != 0) @(negedge i_clk);
                end
                w = make_word(rand_energy(sb.melt_reg), rand_damage(),
                              rand_stress(scale), rand_stress(scale), rand_stress(scale),
                              rand_stress(scale), rand_stress(scale));
                send_particle(w);
            end
            drain();
        end

        // report the checked words, the mismatches and the verdict
        $display("Checked %0d result words over %0d register settings,", sb.checked,
                 NUM_PHASES + 2);
        $display("with queue stalls on both sides and %0d mismatches.", mismatches);
        if (mismatches == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/vmsr_pkg.sv
rtl/vmsr_fifo.sv
rtl/vmsr_front.sv
rtl/vmsr_back.sv
rtl/von_mises_stress_reduction.sv
test/tb_von_mises_stress_reduction.sv
